### sv/gcli_pkg.sv
// ----------------------------------------------------------------------------
// gcli_pkg
// Shared types and constants for the grid coordinate to linear index block.
// ----------------------------------------------------------------------------
package gcli_pkg;

  // Fixed field widths of the interface.
  localparam int COORDS  = 4;
  localparam int COORD_W = 12;
  localparam int NODE_W  = 11;
  localparam int DOF_W   = 4;
  localparam int DOFS_W  = 5;
  localparam int INDEX_W = 44;
  localparam int CFG_W   = 11;
  localparam int CFG_A_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_A_W-1:0] {
    REG_DIM_COUNT  = 3'd0,
    REG_NODES_DIM0 = 3'd1,
    REG_NODES_DIM1 = 3'd2,
    REG_NODES_DIM2 = 3'd3,
    REG_NODES_DIM3 = 3'd4,
    REG_PERIODIC   = 3'd5,
    REG_DOF_COUNT  = 3'd6
  } cfg_reg_t;

  // Per-point side information that travels with each pipeline stage.
  typedef struct packed {
    logic             drop;
    logic             last;
    logic [DOF_W-1:0] dof;
  } pt_ctl_t;

  // Configuration after clamping, as seen by the datapath.
  typedef struct packed {
    logic [COORDS-1:0]             used;
    logic [COORDS-1:0]             periodic;
    logic [COORDS-1:0][NODE_W-1:0] nodes;
    logic [DOFS_W-1:0]             dofs;
  } grid_cfg_t;

endpackage

### sv/gcli_wrap.sv
// ----------------------------------------------------------------------------
// gcli_wrap
// First pipeline stage: periodic wrap, range check and dof check per point.
// ----------------------------------------------------------------------------
module gcli_wrap (
  input  logic                                                       clk,
  input  logic                                                       en,
  input  logic [gcli_pkg::COORDS-1:0][gcli_pkg::COORD_W-1:0]         coord,
  input  logic [gcli_pkg::DOF_W-1:0]                                 dof_index,
  input  logic                                                       last_in_batch,
  input  gcli_pkg::grid_cfg_t                                        cfg,
  output logic [gcli_pkg::COORDS-1:0][gcli_pkg::NODE_W-1:0]          x,
  output gcli_pkg::pt_ctl_t                                          ctl
);

  logic signed [gcli_pkg::COORD_W:0]                   xs;
  logic signed [gcli_pkg::COORD_W:0]                   ns;
  logic signed [gcli_pkg::COORD_W:0]                   xw;
  logic                                                bad;
  logic                                                drop_c;
  logic [gcli_pkg::COORDS-1:0][gcli_pkg::NODE_W-1:0]   x_c;

  // Wrap each coordinate once, then check that it lies inside its dimension.
  // Dimensions not in use contribute zero and never discard the point.
  always_comb begin
    drop_c = 1'b0;
    xs     = '0;
    ns     = '0;
    xw     = '0;
    bad    = 1'b0;
    for (int k = 0; k < gcli_pkg::COORDS; k++) begin
      xs  = {coord[k][gcli_pkg::COORD_W-1], coord[k]};
      ns  = {2'b00, cfg.nodes[k]};
      xw  = xs;
      bad = 1'b0;
      if (xs < 0) begin
        if (cfg.periodic[k]) begin
          xw = xs + ns;
        end else begin
          bad = 1'b1;
        end
      end else if (xs >= ns) begin
        if (cfg.periodic[k]) begin
          xw = xs - ns;
        end else begin
          bad = 1'b1;
        end
      end
      if (xw < 0 || xw >= ns) begin
        bad = 1'b1;
      end
      x_c[k] = cfg.used[k] ? xw[gcli_pkg::NODE_W-1:0] : '0;
      if (cfg.used[k] && bad) begin
        drop_c = 1'b1;
      end
    end
    if ({1'b0, dof_index} >= cfg.dofs) begin
      drop_c = 1'b1;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      x        <= x_c;
      ctl.drop <= drop_c;
      ctl.last <= last_in_batch;
      ctl.dof  <= dof_index;
    end
  end

endmodule

### sv/gcli_mac.sv
// ----------------------------------------------------------------------------
// gcli_mac
// One registered multiply-add step: result = acc * mul + add, truncated.
// ----------------------------------------------------------------------------
module gcli_mac #(
  parameter int A_W = 11,
  parameter int M_W = 11,
  parameter int D_W = 11,
  parameter int O_W = 22
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [A_W-1:0]           acc,
  input  logic [M_W-1:0]           mul,
  input  logic [D_W-1:0]           add,
  input  gcli_pkg::pt_ctl_t        ctl_in,
  output logic [O_W-1:0]           result,
  output gcli_pkg::pt_ctl_t        ctl_out
);

  localparam int P_W = A_W + M_W + 1;

  logic [P_W-1:0] prod;
  logic [P_W-1:0] sum;

  // One Horner step of the row-major index.
  always_comb begin
    prod = P_W'(acc) * P_W'(mul);
    sum  = prod + P_W'(add);
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      result  <= O_W'(sum);
      ctl_out <= ctl_in;
    end
  end

endmodule

### sv/grid_coordinate_to_linear_index.sv
// ----------------------------------------------------------------------------
// grid_coordinate_to_linear_index
// Maps a grid point and a dof index to its flat row-major vector index.
// ----------------------------------------------------------------------------
// Each input transfer passes through one register per stage; the dof stage
//   register drives the output channel.
// Throughput: one point per cycle; stalls back up stage by stage, bubbles fill.
// The depth is set by the wrap stage, three Horner multiply-add stages and
//   the final multiply by the dof count.
// Reset clears all stage valid bits and loads every configuration register with its default.
// ----------------------------------------------------------------------------
module grid_coordinate_to_linear_index #(
  parameter int MAX_DIMS  = 4,
  parameter int MAX_NODES = 1024,
  parameter int MAX_DOF   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write,
  input  logic [gcli_pkg::CFG_A_W-1:0]         cfg_index,
  input  logic [gcli_pkg::CFG_W-1:0]           cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gcli_pkg::COORD_W-1:0]  coord_0,
  input  logic signed [gcli_pkg::COORD_W-1:0]  coord_1,
  input  logic signed [gcli_pkg::COORD_W-1:0]  coord_2,
  input  logic signed [gcli_pkg::COORD_W-1:0]  coord_3,
  input  logic [gcli_pkg::DOF_W-1:0]           dof_index,
  input  logic                                 last_in_batch,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [gcli_pkg::INDEX_W-1:0]         linear_index,
  output logic                                 discarded,
  output logic                                 last_out
);

  localparam int NW = gcli_pkg::NODE_W;
  localparam int STAGES = 5;
  localparam logic [3:0]  MAX_DIMS_V  = 4'(MAX_DIMS);
  localparam logic [16:0] MAX_NODES_V = 17'(MAX_NODES);
  localparam logic [8:0]  MAX_DOF_V   = 9'(MAX_DOF);

  // Configuration registers.
  logic [2:0]                           dim_count;
  logic [gcli_pkg::COORDS-1:0][NW-1:0]  nodes_dim;
  logic [gcli_pkg::COORDS-1:0]          periodic_mask;
  logic [gcli_pkg::DOFS_W-1:0]          dof_count;

  gcli_pkg::grid_cfg_t                  cfg;
  logic [3:0]                           dims;
  logic [gcli_pkg::COORDS-1:0][NW-1:0]  n_eff;

  // Pipeline control.
  logic [STAGES:1]                      v;
  logic [STAGES+1:1]                    rdy;

  // Pipeline payload.
  logic [gcli_pkg::COORDS-1:0][gcli_pkg::COORD_W-1:0] coord_all;
  logic [gcli_pkg::COORDS-1:0][NW-1:0]  x1;
  gcli_pkg::pt_ctl_t                    ctl1, ctl2, ctl3, ctl4, ctl5;
  logic [2*NW-1:0]                      acc2;
  logic [3*NW-1:0]                      acc3;
  logic [gcli_pkg::INDEX_W-1:0]         acc4;
  logic [gcli_pkg::INDEX_W-1:0]         idx5;
  logic [NW-1:0]                        x2_2, x2_3, x3_3;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count     <= 3'd1;
      nodes_dim     <= {gcli_pkg::COORDS{NW'(1)}};
      periodic_mask <= '0;
      dof_count     <= gcli_pkg::DOFS_W'(1);
    end else if (cfg_write) begin
      case (gcli_pkg::cfg_reg_t'(cfg_index))
        gcli_pkg::REG_DIM_COUNT:  dim_count     <= cfg_data[2:0];
        gcli_pkg::REG_NODES_DIM0: nodes_dim[0]  <= cfg_data;
        gcli_pkg::REG_NODES_DIM1: nodes_dim[1]  <= cfg_data;
        gcli_pkg::REG_NODES_DIM2: nodes_dim[2]  <= cfg_data;
        gcli_pkg::REG_NODES_DIM3: nodes_dim[3]  <= cfg_data;
        gcli_pkg::REG_PERIODIC:   periodic_mask <= cfg_data[gcli_pkg::COORDS-1:0];
        gcli_pkg::REG_DOF_COUNT:  dof_count     <= cfg_data[gcli_pkg::DOFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configuration to the supported limits.
  always_comb begin
    dims = {1'b0, dim_count};
    if (dims == 4'd0) begin
      dims = 4'd1;
    end
    if (dims > MAX_DIMS_V) begin
      dims = MAX_DIMS_V;
    end
    if (dims > 4'(gcli_pkg::COORDS)) begin
      dims = 4'(gcli_pkg::COORDS);
    end
    for (int k = 0; k < gcli_pkg::COORDS; k++) begin
      cfg.used[k]  = 4'(k) < dims;
      cfg.nodes[k] = ({6'b0, nodes_dim[k]} > MAX_NODES_V) ?
                     MAX_NODES_V[NW-1:0] : nodes_dim[k];
      n_eff[k]     = cfg.used[k] ? cfg.nodes[k] : NW'(1);
    end
    cfg.periodic = periodic_mask;
    cfg.dofs     = ({4'b0, dof_count} > MAX_DOF_V) ?
                   MAX_DOF_V[gcli_pkg::DOFS_W-1:0] : dof_count;
  end

  // Each stage loads when it is empty or its successor takes its item.
  always_comb begin
    rdy[STAGES+1] = !out_stall;
    for (int k = STAGES; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: wrap and range check.
  assign coord_all = {coord_3, coord_2, coord_1, coord_0};

  gcli_wrap u_wrap (
    .clk           (clk),
    .en            (rdy[1]),
    .coord         (coord_all),
    .dof_index     (dof_index),
    .last_in_batch (last_in_batch),
    .cfg           (cfg),
    .x             (x1),
    .ctl           (ctl1)
  );

  // Stages 2 to 4: Horner steps over the faster dimensions.
  gcli_mac #(.A_W(NW), .M_W(NW), .D_W(NW), .O_W(2*NW)) u_mac1 (
    .clk     (clk),
    .en      (rdy[2]),
    .acc     (x1[0]),
    .mul     (n_eff[1]),
    .add     (x1[1]),
    .ctl_in  (ctl1),
    .result  (acc2),
    .ctl_out (ctl2)
  );

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      x2_2 <= x1[2];
      x2_3 <= x1[3];
    end
    if (rdy[3]) begin
      x3_3 <= x2_3;
    end
  end

  gcli_mac #(.A_W(2*NW), .M_W(NW), .D_W(NW), .O_W(3*NW)) u_mac2 (
    .clk     (clk),
    .en      (rdy[3]),
    .acc     (acc2),
    .mul     (n_eff[2]),
    .add     (x2_2),
    .ctl_in  (ctl2),
    .result  (acc3),
    .ctl_out (ctl3)
  );

  gcli_mac #(.A_W(3*NW), .M_W(NW), .D_W(NW), .O_W(gcli_pkg::INDEX_W)) u_mac3 (
    .clk     (clk),
    .en      (rdy[4]),
    .acc     (acc3),
    .mul     (n_eff[3]),
    .add     (x3_3),
    .ctl_in  (ctl3),
    .result  (acc4),
    .ctl_out (ctl4)
  );

  // Stage 5: scale by the dof count and add the dof index.
  gcli_mac #(.A_W(gcli_pkg::INDEX_W), .M_W(gcli_pkg::DOFS_W), .D_W(gcli_pkg::DOF_W),
             .O_W(gcli_pkg::INDEX_W)) u_mac_dof (
    .clk     (clk),
    .en      (rdy[5]),
    .acc     (acc4),
    .mul     (cfg.dofs),
    .add     (ctl4.dof),
    .ctl_in  (ctl4),
    .result  (idx5),
    .ctl_out (ctl5)
  );

  // Output register drives the result channel.
  assign out_valid    = v[STAGES];
  assign linear_index = ctl5.drop ? '0 : idx5;
  assign discarded    = ctl5.drop;
  assign last_out     = ctl5.last;

  // The input side only stalls when every stage holds an item.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&v) && out_stall))
    else $error("input stalled while the pipeline has room");

  // A transfer with an out-of-range dof index is marked discarded in stage 1.
  a_dof_drop: assert property (@(posedge clk) disable iff (rst)
    (in_valid && rdy[1] && ({1'b0, dof_index} >= cfg.dofs)) |=> (v[1] && ctl1.drop))
    else $error("bad dof index not discarded");

  // A kept point has its slowest coordinate inside its dimension.
  a_coord_in_range: assert property (@(posedge clk) disable iff (rst)
    (v[1] && !ctl1.drop) |-> (x1[0] < cfg.nodes[0]))
    else $error("kept point with coordinate out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

### tb/tb_grid_coordinate_to_linear_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_coordinate_to_linear_index
// Self-checking testbench for the grid point to linear index block.
// A local predictor mirrors the register file and computes the row-major
// index for every accepted point. Results are checked in order, field by
// field. Directed tests cover boundaries, wrapping and register saturation,
// then random grids run with random pauses on both channels.
// ----------------------------------------------------------------------------
module tb_grid_coordinate_to_linear_index;

  localparam int DIM_CAP      = 4;
  localparam int NODE_CAP     = 1024;
  localparam int DOF_CAP      = 16;
  localparam int PIPE_LATENCY = 5;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PRINT_LIMIT  = 100;

  // One grid point as offered on the input channel.
  typedef struct packed {
    logic [gcli_pkg::COORDS-1:0][gcli_pkg::COORD_W-1:0] coord;
    logic [gcli_pkg::DOF_W-1:0]                         dof;
    logic                                               last;
  } grid_point_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [gcli_pkg::INDEX_W-1:0] index;
    logic                         discarded;
    logic                         last;
  } flat_index_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_write;
  logic [gcli_pkg::CFG_A_W-1:0]        cfg_index;
  logic [gcli_pkg::CFG_W-1:0]          cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [gcli_pkg::COORD_W-1:0] coord_0;
  logic signed [gcli_pkg::COORD_W-1:0] coord_1;
  logic signed [gcli_pkg::COORD_W-1:0] coord_2;
  logic signed [gcli_pkg::COORD_W-1:0] coord_3;
  logic [gcli_pkg::DOF_W-1:0]          dof_index;
  logic                                last_in_batch;
  logic                                out_valid;
  logic                                out_stall;
  logic [gcli_pkg::INDEX_W-1:0]        linear_index;
  logic                                discarded;
  logic                                last_out;

  // Local copy of the register file.
  logic [2:0]                  dim_count_q;
  logic [gcli_pkg::NODE_W-1:0] nodes_q [gcli_pkg::COORDS];
  logic [3:0]                  periodic_q;
  logic [gcli_pkg::DOFS_W-1:0] dof_count_q;

  flat_index_t pending_indices[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 9;
  int          sink_stall_pct = 9;
  int          hold_request   = 0;

  grid_coordinate_to_linear_index #(
    .MAX_DIMS (DIM_CAP),
    .MAX_NODES(NODE_CAP),
    .MAX_DOF  (DOF_CAP)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .coord_0      (coord_0),
    .coord_1      (coord_1),
    .coord_2      (coord_2),
    .coord_3      (coord_3),
    .dof_index    (dof_index),
    .last_in_batch(last_in_batch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .linear_index (linear_index),
    .discarded    (discarded),
    .last_out     (last_out)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective node count of one dimension after saturation.
  function automatic int node_cap(int k);
    return (nodes_q[k] > NODE_CAP) ? NODE_CAP : int'(nodes_q[k]);
  endfunction

  // Effective dof count after saturation.
  function automatic int dof_limit();
    return (dof_count_q > DOF_CAP) ? DOF_CAP : int'(dof_count_q);
  endfunction

  // Computes the flat index of one point from the current register copy.
  // The fastest dimension is walked first so the stride builds up.
  function automatic flat_index_t predict_flat_index(grid_point_t p);
    flat_index_t       r;
    int                dims;
    int                dofs;
    int                n;
    int                x;
    logic              drop;
    longint unsigned   stride;
    longint unsigned   acc;
    dims = (dim_count_q == 0) ? 1 : (dim_count_q > DIM_CAP) ? DIM_CAP : int'(dim_count_q);
    dofs = dof_limit();
    drop = 1'b0;
    stride = 1;
    acc = 0;
    for (int k = dims - 1; k >= 0; k--) begin
      if (!drop) begin
        n = node_cap(k);
        x = int'($signed(p.coord[k]));
        // A periodic coordinate moves by one node count, no more.
        if (x < 0) begin
          if (periodic_q[k]) x = x + n;
          else drop = 1'b1;
        end else if (x >= n) begin
          if (periodic_q[k]) x = x - n;
          else drop = 1'b1;
        end
        if (x < 0 || x >= n) drop = 1'b1;
        if (!drop) begin
          acc = acc + stride * x;
          stride = stride * n;
        end
      end
    end
    if (p.dof >= dofs) drop = 1'b1;
    r.index     = drop ? '0 : gcli_pkg::INDEX_W'(acc * dofs + p.dof);
    r.discarded = drop;
    r.last      = p.last;
    return r;
  endfunction

  function automatic grid_point_t make_point(int c0, int c1, int c2, int c3, int dof,
                                             bit last);
    grid_point_t p;
    p.coord[0] = c0[gcli_pkg::COORD_W-1:0];
    p.coord[1] = c1[gcli_pkg::COORD_W-1:0];
    p.coord[2] = c2[gcli_pkg::COORD_W-1:0];
    p.coord[3] = c3[gcli_pkg::COORD_W-1:0];
    p.dof      = dof[gcli_pkg::DOF_W-1:0];
    p.last     = last;
    return p;
  endfunction

  // Picks a coordinate that lands mostly inside the grid, with a share just
  // outside either edge, beyond one wrap, and anywhere in the field.
  function automatic int pick_coord(int n);
    int r;
    r = $urandom_range(99);
    if (n == 0 || r >= 95) return $signed(gcli_pkg::COORD_W'($urandom));
    if (r < 82) return $urandom_range(n - 1, 0);
    if (r < 88) return -int'($urandom_range(n, 1));
    if (r < 93) return n + int'($urandom_range(n - 1, 0));
    return ($urandom_range(1, 0) != 0) ? -n - 1 : 2 * n;
  endfunction

  function automatic grid_point_t random_point();
    int c [gcli_pkg::COORDS];
    int dofs;
    int dof;
    for (int k = 0; k < gcli_pkg::COORDS; k++) c[k] = pick_coord(node_cap(k));
    dofs = dof_limit();
    if (dofs > 0 && $urandom_range(99) < 88) dof = $urandom_range(dofs - 1, 0);
    else dof = $urandom_range(15, 0);
    return make_point(c[0], c[1], c[2], c[3], dof, 1'($urandom_range(1, 0)));
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("ERROR %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
  endtask

  // Offers one point and returns at the edge where the transfer happens.
  task automatic send_point(grid_point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    coord_0       <= p.coord[0];
    coord_1       <= p.coord[1];
    coord_2       <= p.coord[2];
    coord_3       <= p.coord[3];
    dof_index     <= p.dof;
    last_in_batch <= p.last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_indices.push_back(predict_flat_index(p));
  endtask

  // Stops offering points and waits until the pipeline has drained.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_indices.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(gcli_pkg::cfg_reg_t r, int value);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= value[gcli_pkg::CFG_W-1:0];
    case (r)
      gcli_pkg::REG_DIM_COUNT:  dim_count_q = value[2:0];
      gcli_pkg::REG_NODES_DIM0: nodes_q[0] = value[gcli_pkg::NODE_W-1:0];
      gcli_pkg::REG_NODES_DIM1: nodes_q[1] = value[gcli_pkg::NODE_W-1:0];
      gcli_pkg::REG_NODES_DIM2: nodes_q[2] = value[gcli_pkg::NODE_W-1:0];
      gcli_pkg::REG_NODES_DIM3: nodes_q[3] = value[gcli_pkg::NODE_W-1:0];
      gcli_pkg::REG_PERIODIC:   periodic_q = value[3:0];
      gcli_pkg::REG_DOF_COUNT:  dof_count_q = value[gcli_pkg::DOFS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drains the block, then rewrites every register.
  task automatic configure_grid(int dims, int n0, int n1, int n2, int n3, int per,
                                int dofs);
    wait_for_idle();
    write_reg(gcli_pkg::REG_DIM_COUNT, dims);
    write_reg(gcli_pkg::REG_NODES_DIM0, n0);
    write_reg(gcli_pkg::REG_NODES_DIM1, n1);
    write_reg(gcli_pkg::REG_NODES_DIM2, n2);
    write_reg(gcli_pkg::REG_NODES_DIM3, n3);
    write_reg(gcli_pkg::REG_PERIODIC, per);
    write_reg(gcli_pkg::REG_DOF_COUNT, dofs);
    cfg_write <= 1'b0;
  endtask

  // Register values straight out of reset: a single node with one dof.
  task automatic test_reset_defaults();
    send_point(make_point(0, 0, 0, 0, 0, 0));
    send_point(make_point(1, 0, 0, 0, 0, 1));
    send_point(make_point(0, 5, 5, 5, 1, 0));
    send_point(make_point(-1, 0, 0, 0, 0, 1));
  endtask

  // Largest grid: the far corner gives the top index; extremes drop or, when periodic, wrap.
  task automatic test_full_range();
    configure_grid(4, NODE_CAP, NODE_CAP, NODE_CAP, NODE_CAP, 0, DOF_CAP);
    send_point(make_point(0, 0, 0, 0, 0, 1));
    send_point(make_point(1023, 1023, 1023, 1023, 15, 0));
    send_point(make_point(-1024, 2047, -1, 0, 3, 1));
    send_point(make_point(0, 0, 0, 2047, 0, 0));
    configure_grid(4, NODE_CAP, NODE_CAP, NODE_CAP, NODE_CAP, 4'hf, DOF_CAP);
    send_point(make_point(-1024, 2047, -1, 1023, 7, 1));
    send_point(make_point(-2048, 0, 0, 0, 0, 0));
  endtask

  // Wrapping on periodic dimensions, a wrap that is not enough, and dof range.
  task automatic test_periodic_wrap();
    configure_grid(4, 5, 7, 3, 2, 4'b1011, 3);
    send_point(make_point(-1, 7, 0, -1, 0, 0));
    send_point(make_point(5, -7, 1, 2, 1, 1));
    send_point(make_point(-6, 0, 0, 0, 0, 0));
    send_point(make_point(10, 0, 0, 0, 0, 1));
    send_point(make_point(0, 0, 3, 0, 0, 0));
    send_point(make_point(0, 0, -1, 0, 0, 1));
    send_point(make_point(4, 6, 2, 1, 2, 0));
    send_point(make_point(4, 6, 2, 1, 3, 1));
  endtask

  // Coordinates of dimensions that are not in use must not matter.
  task automatic test_unused_dimensions();
    configure_grid(2, 4, 4, 0, 0, 0, 4);
    send_point(make_point(3, 3, -2048, 2047, 3, 1));
    send_point(make_point(1, 2, 5, -1, 0, 0));
  endtask

  // Out-of-range register values: clamping and zero counts.
  task automatic test_register_saturation();
    configure_grid(0, 3, 1, 1, 1, 0, 31);
    send_point(make_point(2, 9, 9, 9, 15, 1));
    configure_grid(7, 2047, 1, 1, 2, 0, DOF_CAP);
    send_point(make_point(1500, 0, 0, 1, 0, 0));
    send_point(make_point(1023, 0, 0, 1, 9, 1));
    configure_grid(1, 0, 1, 1, 1, 1, 5);
    send_point(make_point(0, 0, 0, 0, 0, 0));
    configure_grid(1, 4, 1, 1, 1, 0, 0);
    send_point(make_point(0, 0, 0, 0, 0, 1));
  endtask

  // The receiver holds off for a long stretch while points keep coming,
  // so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    configure_grid(3, 8, 8, 8, 1, 4'b0101, 4);
    send_idle_pct = 0;
    hold_request  = 64;
    repeat (40) send_point(random_point());
    send_idle_pct = 9;
  endtask

  // Random grids, mostly inside the legal register ranges.
  task automatic test_random_grids();
    int r;
    int dims;
    int dofs;
    int n [gcli_pkg::COORDS];
    for (int phase = 0; phase < 6; phase++) begin
      dims = ($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(7, 0);
      for (int k = 0; k < gcli_pkg::COORDS; k++) begin
        r = $urandom_range(99);
        if (r < 70) n[k] = $urandom_range(12, 1);
        else if (r < 80) n[k] = $urandom_range(NODE_CAP, 13);
        else if (r < 88) n[k] = NODE_CAP;
        else if (r < 95) n[k] = $urandom_range(2047, NODE_CAP + 1);
        else n[k] = 0;
      end
      dofs = ($urandom_range(99) < 85) ? $urandom_range(DOF_CAP, 1) : $urandom_range(31, 0);
      configure_grid(dims, n[0], n[1], n[2], n[3], $urandom_range(15, 0), dofs);
      // One phase streams with no pauses on either side.
      send_idle_pct  = (phase == 2) ? 0 : 9;
      sink_stall_pct = (phase == 2) ? 0 : 9;
      repeat (115) send_point(random_point());
    end
    send_idle_pct  = 9;
    sink_stall_pct = 9;
  endtask

  // Output side stall pattern, with a long hold-off on request.
  initial begin : sink_stall_driver
    int hold_left;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // Compares every output transfer with the oldest predicted index.
  always @(posedge clk) begin : result_checker
    flat_index_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_indices.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(0), 64'(linear_index));
      end else begin
        want = pending_indices.pop_front();
        if (linear_index !== want.index)
          report_mismatch("linear_index", 64'(want.index), 64'(linear_index));
        if (discarded !== want.discarded)
          report_mismatch("discarded", 64'(want.discarded), 64'(discarded));
        if (last_out !== want.last)
          report_mismatch("last_out", 64'(want.last), 64'(last_out));
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Test sequence.
  initial begin : test_sequence
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = gcli_pkg::REG_DIM_COUNT;
    cfg_data      = '0;
    in_valid      = 1'b0;
    coord_0       = '0;
    coord_1       = '0;
    coord_2       = '0;
    coord_3       = '0;
    dof_index     = '0;
    last_in_batch = 1'b0;
    dim_count_q   = 3'd1;
    for (int k = 0; k < gcli_pkg::COORDS; k++) nodes_q[k] = gcli_pkg::NODE_W'(1);
    periodic_q    = 4'd0;
    dof_count_q   = gcli_pkg::DOFS_W'(1);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_full_range();
    test_periodic_wrap();
    test_unused_dimensions();
    test_register_saturation();
    test_backpressure();
    test_random_grids();
    wait_for_idle();
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### grid_coordinate_to_linear_index.f
sv/gcli_pkg.sv
sv/gcli_wrap.sv
sv/gcli_mac.sv
sv/grid_coordinate_to_linear_index.sv
tb/tb_grid_coordinate_to_linear_index.sv
